// File: src/vsimex_pkg.sv
// Shared types and constants for the variable-step IMEX weight block.
// Used by the front end, job queue, back end, arithmetic lanes and top level.
package vsimex_pkg;

  localparam int unsigned TW    = 64;        // time and weight width
  localparam int unsigned NLEV  = 3;         // old time levels
  localparam int unsigned PW1   = 2 * TW;    // product of two differences
  localparam int unsigned PW2   = 3 * TW;    // product of three differences
  localparam int unsigned NW    = PW1 + 2;   // numerator magnitude (sum of three products)
  localparam int unsigned SW    = NW + 1;    // signed sum
  localparam int unsigned STEPS = TW;        // iterations per multiply or divide pass
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned QDEPTH = 2;

  localparam logic [1:0] ORDER_ONE   = 2'd1;
  localparam logic [1:0] ORDER_TWO   = 2'd2;
  localparam logic [1:0] ORDER_THREE = 2'd3;

  // slots of the old-level pair differences
  localparam int unsigned PAIR01 = 0;
  localparam int unsigned PAIR02 = 1;
  localparam int unsigned PAIR12 = 2;

  typedef struct packed {
    logic [NLEV-1:0][TW-1:0] a_mag;   // |t_next - t_j|
    logic [NLEV-1:0]         a_neg;
    logic [NLEV-1:0][TW-1:0] b_mag;   // |t_i - t_j| for pairs 01, 02, 12
    logic [NLEV-1:0]         b_neg;
    logic [NLEV-1:0]         used;
    logic [1:0]              order;
    logic                    fault;
  } job_t;

  typedef struct packed {
    logic [3:0][TW-1:0] lhs;
    logic [2:0][TW-1:0] rhs;
    logic [1:0]         order;
    logic               fault;
  } res_t;

endpackage

// File: src/variable_step_imex_coefficients.sv
// Top level of the variable-step IMEX weight block.
// Depends on vsimex_pkg, vsimex_front, vsimex_fifo and vsimex_back.
//
// Usage:
//   Command side: drive the four time levels (signed fixed point, FRAC_BITS
//   fraction bits) with start high; the command is taken at a rising edge
//   where start is high and busy is low. busy is high only while the
//   two-entry job queue is full.
//   Result side: done_o is high for one cycle with all seven weights,
//   formula_order_o and div_fault_o. The receiver cannot stall the block.
//   Flow: a taken command enters the job queue; the idle back end pops it
//   and runs three passes of bit-per-cycle lanes: a shift-add multiply
//   for the pair products, a second one for the triple products, and a
//   restoring divide for the quotients. The back end holds one job at a
//   time; up to two more commands are taken while a job is in the back
//   end.
//   Reset: the queue empties and the back end returns to idle; no result
//   is produced until a new command is taken.
module variable_step_imex_coefficients #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] time_oldest_i,
  input  logic signed [63:0] time_older_i,
  input  logic signed [63:0] time_current_i,
  input  logic signed [63:0] time_next_i,
  output logic               done_o,
  output logic signed [63:0] lhs_oldest_o,
  output logic signed [63:0] lhs_older_o,
  output logic signed [63:0] lhs_current_o,
  output logic signed [63:0] lhs_next_o,
  output logic signed [63:0] rhs_oldest_o,
  output logic signed [63:0] rhs_older_o,
  output logic signed [63:0] rhs_current_o,
  output logic [1:0]         formula_order_o,
  output logic               div_fault_o
);

  logic             push, full, empty, pop;
  vsimex_pkg::job_t job_in, job_head;
  vsimex_pkg::res_t res;

  vsimex_front u_front (
    .start_i (start),
    .full_i  (full),
    .t0_i    (time_oldest_i),
    .t1_i    (time_older_i),
    .t2_i    (time_current_i),
    .t3_i    (time_next_i),
    .push_o  (push),
    .busy_o  (busy),
    .job_o   (job_in)
  );

  vsimex_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_head),
    .empty_o (empty),
    .full_o  (full)
  );

  vsimex_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (~empty),
    .job_i   (job_head),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign lhs_oldest_o    = res.lhs[0];
  assign lhs_older_o     = res.lhs[1];
  assign lhs_current_o   = res.lhs[2];
  assign lhs_next_o      = res.lhs[3];
  assign rhs_oldest_o    = res.rhs[0];
  assign rhs_older_o     = res.rhs[1];
  assign rhs_current_o   = res.rhs[2];
  assign formula_order_o = res.order;
  assign div_fault_o     = res.fault;

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe on two cycles in a row");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && div_fault_o) |-> (lhs_oldest_o == '0 && lhs_older_o == '0 &&
      lhs_current_o == '0 && lhs_next_o == '0 && rhs_oldest_o == '0 &&
      rhs_older_o == '0 && rhs_current_o == '0))
    else $error("nonzero weight with divide fault");

  a_order_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && formula_order_o == vsimex_pkg::ORDER_ONE) |->
      (rhs_oldest_o == '0 && rhs_older_o == '0 && lhs_oldest_o == '0))
    else $error("dropped level has a weight at first order");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a command");

endmodule

// File: src/vsimex_front.sv
// Front end: takes a command, forms the level differences, order and fault.
// Depends on vsimex_pkg.
module vsimex_front (
  input  logic                           start_i,
  input  logic                           full_i,
  input  logic signed [vsimex_pkg::TW-1:0] t0_i,
  input  logic signed [vsimex_pkg::TW-1:0] t1_i,
  input  logic signed [vsimex_pkg::TW-1:0] t2_i,
  input  logic signed [vsimex_pkg::TW-1:0] t3_i,
  output logic                           push_o,
  output logic                           busy_o,
  output vsimex_pkg::job_t               job_o
);

  localparam int unsigned TW = vsimex_pkg::TW;

  // exact x - y as {sign, magnitude}; the magnitude always fits TW bits
  function automatic logic [TW:0] sdiff(input logic [TW-1:0] x, input logic [TW-1:0] y);
    logic [TW:0] d;
    logic [TW:0] n;
    d = {x[TW-1], x} - {y[TW-1], y};
    n = (~d) + (TW+1)'(1);
    return d[TW] ? {1'b1, n[TW-1:0]} : {1'b0, d[TW-1:0]};
  endfunction

  logic eq01, eq02, eq12, eq03, eq13, eq23;
  logic [TW:0] a0, a1, a2, b01, b02, b12;

  always_comb begin
    eq01 = t0_i == t1_i;
    eq02 = t0_i == t2_i;
    eq12 = t1_i == t2_i;
    eq03 = t0_i == t3_i;
    eq13 = t1_i == t3_i;
    eq23 = t2_i == t3_i;

    a0  = sdiff(t3_i, t0_i);
    a1  = sdiff(t3_i, t1_i);
    a2  = sdiff(t3_i, t2_i);
    b01 = sdiff(t0_i, t1_i);
    b02 = sdiff(t0_i, t2_i);
    b12 = sdiff(t1_i, t2_i);

    priority if (!eq01) begin
      job_o.order = vsimex_pkg::ORDER_THREE;
    end else if (eq12) begin
      job_o.order = vsimex_pkg::ORDER_ONE;
    end else begin
      job_o.order = vsimex_pkg::ORDER_TWO;
    end
    job_o.used[0] = job_o.order == vsimex_pkg::ORDER_THREE;
    job_o.used[1] = job_o.order != vsimex_pkg::ORDER_ONE;
    job_o.used[2] = 1'b1;

    job_o.fault = (job_o.used[0] & job_o.used[1] & eq01) | (job_o.used[0] & eq02) |
                  (job_o.used[1] & eq12) | (job_o.used[0] & eq03) |
                  (job_o.used[1] & eq13) | eq23;

    job_o.a_mag[0] = a0[TW-1:0];
    job_o.a_mag[1] = a1[TW-1:0];
    job_o.a_mag[2] = a2[TW-1:0];
    job_o.a_neg    = {a2[TW], a1[TW], a0[TW]};
    job_o.b_mag[vsimex_pkg::PAIR01] = b01[TW-1:0];
    job_o.b_mag[vsimex_pkg::PAIR02] = b02[TW-1:0];
    job_o.b_mag[vsimex_pkg::PAIR12] = b12[TW-1:0];
    job_o.b_neg[vsimex_pkg::PAIR01] = b01[TW];
    job_o.b_neg[vsimex_pkg::PAIR02] = b02[TW];
    job_o.b_neg[vsimex_pkg::PAIR12] = b12[TW];
  end

  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

endmodule

// File: src/vsimex_fifo.sv
// Short job queue between the front end and the back end.
// Depends on vsimex_pkg (job_t, QDEPTH).
module vsimex_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vsimex_pkg::job_t data_i,
  input  logic             pop_i,
  output vsimex_pkg::job_t data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned DEPTH = vsimex_pkg::QDEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  vsimex_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (AW+1)'(DEPTH);

endmodule

// File: src/vsimex_mul.sv
// Shift-add multiplier lane: AW x TW unsigned, one multiplier bit per cycle while step_i is high.
// Depends on vsimex_pkg (TW).
module vsimex_mul #(
  parameter int unsigned AW = 64
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         step_i,
  input  logic [AW-1:0]                a_i,
  input  logic [vsimex_pkg::TW-1:0]    b_i,
  output logic [AW+vsimex_pkg::TW-1:0] prod_o
);

  localparam int unsigned TW = vsimex_pkg::TW;

  logic [AW-1:0]    a_q;
  logic [AW+TW-1:0] prod_q, prod_d;
  logic [AW:0]      upper;

  // low half holds the remaining multiplier bits, high half the partial sum
  always_comb begin
    upper  = {1'b0, prod_q[AW+TW-1:TW]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {upper, prod_q[TW-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q    <= a_i;
      prod_q <= {{AW{1'b0}}, b_i};
    end else if (step_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: src/vsimex_div.sv
// Restoring divider lane: round(num * 2^SHIFT / den), saturated to TW bits.
// One quotient bit per cycle while step_i is high; depends on vsimex_pkg.
module vsimex_div #(
  parameter int unsigned SHIFT = 64
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic                          step_i,
  input  logic [vsimex_pkg::NW-1:0]     num_i,
  input  logic [vsimex_pkg::PW2-1:0]    den_i,
  input  logic                          neg_i,
  output logic signed [vsimex_pkg::TW-1:0] quo_o
);

  localparam int unsigned TW = vsimex_pkg::TW;
  localparam int unsigned DW = vsimex_pkg::PW2;
  localparam int unsigned XW = vsimex_pkg::NW + SHIFT;

  logic [XW-1:0] wide;
  logic [DW:0]   r0, trial, diff;
  logic [DW-1:0] rem_q, den_q;
  logic [TW-1:0] quo_q, low_q;
  logic          ovf_q, neg_q, ge, rnd;
  logic [TW:0]   q65;

  always_comb begin
    wide  = {num_i, {SHIFT{1'b0}}};
    r0    = (DW+1)'(wide[XW-1:TW]);
    trial = {rem_q, low_q[TW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // quotient of 2^TW or more saturates in any case
      ovf_q <= r0 >= {1'b0, den_i};
      rem_q <= r0[DW-1:0];
      den_q <= den_i;
      low_q <= wide[TW-1:0];
      quo_q <= '0;
      neg_q <= neg_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[TW-2:0], ge};
      low_q <= {low_q[TW-2:0], 1'b0};
    end
  end

  always_comb begin
    rnd = {rem_q, 1'b0} >= {1'b0, den_q};
    q65 = {1'b0, quo_q} + (TW+1)'(rnd);
    if (!neg_q) begin
      if (ovf_q || q65 > {2'b00, {(TW-1){1'b1}}}) begin
        quo_o = {1'b0, {(TW-1){1'b1}}};
      end else begin
        quo_o = q65[TW-1:0];
      end
    end else begin
      if (ovf_q || q65 > {2'b01, {(TW-1){1'b0}}}) begin
        quo_o = {1'b1, {(TW-1){1'b0}}};
      end else begin
        quo_o = (~q65[TW-1:0]) + TW'(1);
      end
    end
  end

endmodule

// File: src/vsimex_back.sv
// Back end: multiplies out the Lagrange products and divides them into weights.
// Depends on vsimex_pkg, vsimex_mul and vsimex_div.
module vsimex_back #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  vsimex_pkg::job_t job_i,
  output logic             pop_o,
  output logic             done_o,
  output vsimex_pkg::res_t res_o
);

  localparam int unsigned TW    = vsimex_pkg::TW;
  localparam int unsigned PW1   = vsimex_pkg::PW1;
  localparam int unsigned PW2   = vsimex_pkg::PW2;
  localparam int unsigned NW    = vsimex_pkg::NW;
  localparam int unsigned SW    = vsimex_pkg::SW;
  localparam int unsigned CNT_W = vsimex_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_LOAD2, S_MUL2, S_SUM, S_LOADD, S_DIV, S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q, last;
  vsimex_pkg::res_t res_q, res_d;

  vsimex_pkg::job_t job_q;
  logic [5:0]       sg1_q, sg1_d;
  logic [NW-1:0]    sum_mag_q;
  logic             sum_neg_q;

  logic [5:0][TW:0]     fx, fy;
  logic [5:0][PW1-1:0]  p1;
  logic [3:0][PW1-1:0]  m2a;
  logic [3:0][TW-1:0]   m2b;
  logic [3:0][PW2-1:0]  p2;
  logic [3:0]           sg2;
  logic [2:0][SW-1:0]   sn;
  logic [SW-1:0]        sum_s, sum_abs;
  logic [6:0][NW-1:0]   dn;
  logic [6:0][PW2-1:0]  dd;
  logic [6:0]           dg;
  logic [6:0][TW-1:0]   dq;

  // unused level contributes a factor of one
  function automatic logic [TW:0] fac(input logic [TW-1:0] mag, input logic neg,
                                      input logic use_lvl);
    return use_lvl ? {neg, mag} : {1'b0, TW'(1)};
  endfunction

  assign pop_o = (state_q == S_IDLE) && valid_i;
  assign last  = cnt_q == CNT_W'(vsimex_pkg::STEPS - 1);

  // first pass: numerators num_i and old-level denominators rden_i
  always_comb begin
    fx[0] = fac(job_i.a_mag[1], job_i.a_neg[1], job_i.used[1]);
    fy[0] = fac(job_i.a_mag[2], job_i.a_neg[2], job_i.used[2]);
    fx[1] = fac(job_i.a_mag[0], job_i.a_neg[0], job_i.used[0]);
    fy[1] = fac(job_i.a_mag[2], job_i.a_neg[2], job_i.used[2]);
    fx[2] = fac(job_i.a_mag[0], job_i.a_neg[0], job_i.used[0]);
    fy[2] = fac(job_i.a_mag[1], job_i.a_neg[1], job_i.used[1]);
    fx[3] = fac(job_i.b_mag[vsimex_pkg::PAIR01], job_i.b_neg[vsimex_pkg::PAIR01],
                job_i.used[1]);
    fy[3] = fac(job_i.b_mag[vsimex_pkg::PAIR02], job_i.b_neg[vsimex_pkg::PAIR02],
                job_i.used[2]);
    fx[4] = fac(job_i.b_mag[vsimex_pkg::PAIR01], ~job_i.b_neg[vsimex_pkg::PAIR01],
                job_i.used[0]);
    fy[4] = fac(job_i.b_mag[vsimex_pkg::PAIR12], job_i.b_neg[vsimex_pkg::PAIR12],
                job_i.used[2]);
    fx[5] = fac(job_i.b_mag[vsimex_pkg::PAIR02], ~job_i.b_neg[vsimex_pkg::PAIR02],
                job_i.used[0]);
    fy[5] = fac(job_i.b_mag[vsimex_pkg::PAIR12], ~job_i.b_neg[vsimex_pkg::PAIR12],
                job_i.used[1]);
    for (int k = 0; k < 6; k++) begin
      sg1_d[k] = fx[k][TW] ^ fy[k][TW];
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_mul1
    vsimex_mul #(.AW(TW)) u_mul (
      .clk_i  (clk_i),
      .load_i (pop_o),
      .step_i (state_q == S_MUL1),
      .a_i    (fx[k][TW-1:0]),
      .b_i    (fy[k][TW-1:0]),
      .prod_o (p1[k])
    );
  end

  // second pass: den_i = rden_i * (t_i - t_next), den3 = num_2 * (t_next - t_2)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2a[i] = p1[3+i];
      m2b[i] = job_q.a_mag[i];
      sg2[i] = sg1_q[3+i] ^ job_q.a_neg[i] ^ 1'b1;
    end
    m2a[3] = p1[2];
    m2b[3] = job_q.a_mag[2];
    sg2[3] = sg1_q[2] ^ job_q.a_neg[2];
  end

  for (genvar k = 0; k < 4; k++) begin : g_mul2
    vsimex_mul #(.AW(PW1)) u_mul (
      .clk_i  (clk_i),
      .load_i (state_q == S_LOAD2),
      .step_i (state_q == S_MUL2),
      .a_i    (m2a[k]),
      .b_i    (m2b[k]),
      .prod_o (p2[k])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sn[i] = !job_q.used[i] ? '0 :
              sg1_q[i] ? (~SW'(p1[i])) + SW'(1) : SW'(p1[i]);
    end
    sum_s   = sn[0] + sn[1] + sn[2];
    sum_abs = sum_s[SW-1] ? (~sum_s) + SW'(1) : sum_s;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      sg1_q <= sg1_d;
    end
    if (state_q == S_SUM) begin
      sum_mag_q <= sum_abs[NW-1:0];
      sum_neg_q <= sum_s[SW-1];
    end
  end

  // lanes 0..2 lhs_i, 3..5 rhs_i, 6 lhs_next
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i]   = NW'(p1[i]);
      dd[i]   = p2[i];
      dg[i]   = sg1_q[i] ^ sg2[i];
      dn[3+i] = NW'(p1[i]);
      dd[3+i] = PW2'(p1[3+i]);
      dg[3+i] = sg1_q[i] ^ sg1_q[3+i];
    end
    dn[6] = sum_mag_q;
    dd[6] = p2[3];
    dg[6] = sum_neg_q ^ sg2[3];
  end

  for (genvar l = 0; l < 7; l++) begin : g_div
    vsimex_div #(.SHIFT((l >= 3 && l < 6) ? FRAC_BITS : 2 * FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .load_i (state_q == S_LOADD),
      .step_i (state_q == S_DIV),
      .num_i  (dn[l]),
      .den_i  (dd[l]),
      .neg_i  (dg[l]),
      .quo_o  (dq[l])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_d.lhs[i] = (job_q.fault || !job_q.used[i]) ? '0 : dq[i];
      res_d.rhs[i] = (job_q.fault || !job_q.used[i]) ? '0 : dq[3+i];
    end
    res_d.lhs[3] = job_q.fault ? '0 : dq[6];
    res_d.order  = job_q.order;
    res_d.fault  = job_q.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (valid_i) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            state_q <= S_LOAD2;
          end
        end
        S_LOAD2: state_q <= S_MUL2;
        S_MUL2: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            state_q <= S_SUM;
          end
        end
        S_SUM:   state_q <= S_LOADD;
        S_LOADD: state_q <= S_DIV;
        S_DIV: begin
          cnt_q <= last ? '0 : cnt_q + 1'b1;
          if (last) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          done_q  <= 1'b1;
          res_q   <= res_d;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
